// ===== src/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and constants of the PackBits decoder: header codes, the
// controller/datapath command and status bundles, and register addresses.
// ----------------------------------------------------------------------------
package pbd_pkg;

    // Configuration port geometry
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    // Register byte addresses
    localparam logic [PADDR_W-1:0] REG_ENABLE = 2'd0;

    // Header that carries no run
    localparam logic [7:0] HDR_SKIP = 8'h80;

    // Largest copy count of one result
    localparam logic [2:0] MAX_COPIES = 3'd4;

    // Decode phase kept between bytes
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } t_phase;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // take the input request this cycle
        logic drain_step;  // emit the next chunk of a repeat run
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;   // output register empty or being taken
        logic repeat_long; // accepted byte opens a repeat of more than one chunk
        logic drain_last;  // pending chunk is the final one of the run
    } t_status;

endpackage

// ===== src/pbd_if.sv =====
// ----------------------------------------------------------------------------
// pbd_if
// Valid/ready channels of the decoder: compressed input bytes and decoded
// results.
// ----------------------------------------------------------------------------
interface pbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_strip;

    modport source (output valid, output in_byte, output end_of_strip, input ready);
    modport sink   (input valid, input in_byte, input end_of_strip, output ready);
endinterface

interface pbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] out_copies;
    logic       last_of_run;

    modport source (output valid, output out_byte, output out_copies, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input out_copies, input last_of_run,
                    output ready);
endinterface

// ===== src/packbits_decoder.sv =====
// ----------------------------------------------------------------------------
// packbits_decoder
// PackBits run-length decoder: one compressed byte per request in, results
// of one to four copies of a data byte out.
//
//   channel   dir   handshake       payload
//   i_in      in    valid/ready     in_byte[7:0], end_of_strip
//   o_out     out   valid/ready     out_byte[7:0], out_copies[2:0], last_of_run
//   apb       in    psel/penable    enable bit at byte address 0
//
// Header and literal bytes are taken one per cycle while the sink keeps up. A
// repeat of more than four copies holds input off while the output register
// drains the rest of the run, one chunk per cycle as the sink allows. The
// single output register sets the pace: a byte is taken when it is empty or
// being read. Reset (synchronous, active low) returns to header decode with decoding enabled.
// ----------------------------------------------------------------------------
module packbits_decoder
    import pbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    pbd_in_if.sink             i_in,
    pbd_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic    enable;
    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;

    // Configuration register
    pbd_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_enable (enable)
    );

    // Controller
    pbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Datapath
    pbd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enable       (enable),
        .i_cmd          (cmd),
        .i_in_byte      (i_in.in_byte),
        .i_end_of_strip (i_in.end_of_strip),
        .i_out_ready    (o_out.ready),
        .o_status       (status),
        .o_out_valid    (out_valid),
        .o_out_byte     (o_out.out_byte),
        .o_out_copies   (o_out.out_copies),
        .o_last_of_run  (o_out.last_of_run)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// ===== src/pbd_regs.sv =====
// ----------------------------------------------------------------------------
// pbd_regs
// APB-style configuration register: holds the PackBits enable bit.
// ----------------------------------------------------------------------------
module pbd_regs
    import pbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic               o_enable
);

    logic r_enable;
    logic n_enable;
    logic wr_en;

    // Only one register: every byte address of the port lies in its word
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Capture the enable bit on a completed write
    always_comb begin
        n_enable = r_enable;
        if (wr_en) begin
            n_enable = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else begin
            r_enable <= n_enable;
        end
    end

    // Read back
    assign prdata   = {{(PDATA_W-1){1'b0}}, r_enable};
    assign o_enable = r_enable;

endmodule

// ===== src/pbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbd_ctrl
// Controller of the decoder: takes input requests, and holds input off while
// a long repeat run drains through the output register.
// ----------------------------------------------------------------------------
module pbd_ctrl
    import pbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_DRAIN  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // Accept only with room in the output register
    assign o_in_ready        = (r_state == ST_ACCEPT) && i_status.slot_free;
    assign o_cmd.accept      = o_in_ready && i_in_valid;
    assign o_cmd.drain_step  = (r_state == ST_DRAIN) && i_status.slot_free;

    // Advance between taking bytes and draining a repeat
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACCEPT: begin
                if (o_cmd.accept && i_status.repeat_long) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (o_cmd.drain_step && i_status.drain_last) begin
                    n_state = ST_ACCEPT;
                end
            end
            default: n_state = ST_ACCEPT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/pbd_dp.sv =====
// ----------------------------------------------------------------------------
// pbd_dp
// Datapath of the decoder: header decode, literal and repeat counters, and
// the output register.
// ----------------------------------------------------------------------------
module pbd_dp
    import pbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_enable,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_strip,
    input  logic       i_out_ready,
    output t_status    o_status,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_out_copies,
    output logic       o_last_of_run
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_remaining;
    logic [7:0] n_remaining;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic [7:0] r_rep_byte;
    logic [7:0] n_rep_byte;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_out_byte;
    logic [7:0] n_out_byte;
    logic [2:0] r_out_copies;
    logic [2:0] n_out_copies;
    logic       r_last;
    logic       n_last;

    logic [7:0] lit_left;
    logic [2:0] first_chunk;
    logic [2:0] next_chunk;

    // Copies in one result: four, or what is left of the run
    function automatic logic [2:0] chunk_of(input logic [7:0] cnt);
        logic [2:0] c;
        c = (cnt > {5'd0, MAX_COPIES}) ? MAX_COPIES : cnt[2:0];
        return c;
    endfunction

    assign lit_left    = r_remaining - 8'd1;
    assign first_chunk = chunk_of(r_remaining);
    assign next_chunk  = chunk_of(r_count);

    assign o_status.slot_free   = !r_out_valid || i_out_ready;
    assign o_status.repeat_long = i_enable && (r_phase == PH_REPEAT)
                                  && (r_remaining > {5'd0, MAX_COPIES});
    assign o_status.drain_last  = (r_count <= {5'd0, MAX_COPIES});

    // Decode the accepted byte or step the drain
    always_comb begin
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_count      = r_count;
        n_rep_byte   = r_rep_byte;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_byte   = r_out_byte;
        n_out_copies = r_out_copies;
        n_last       = r_last;

        if (i_cmd.accept) begin
            if (!i_enable) begin
                // Pass through
                n_out_valid  = 1'b1;
                n_out_byte   = i_in_byte;
                n_out_copies = 3'd1;
                n_last       = 1'b0;
                n_phase      = PH_HEADER;
                n_remaining  = 8'd0;
            end else begin
                case (r_phase)
                    PH_LITERAL: begin
                        n_out_valid  = 1'b1;
                        n_out_byte   = i_in_byte;
                        n_out_copies = 3'd1;
                        n_last       = (lit_left == 8'd0) || i_end_of_strip;
                        n_remaining  = lit_left;
                        if (lit_left == 8'd0) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    PH_REPEAT: begin
                        // First chunk now, the rest drains from r_count
                        n_out_valid  = 1'b1;
                        n_out_byte   = i_in_byte;
                        n_out_copies = first_chunk;
                        n_last       = (r_remaining <= {5'd0, MAX_COPIES});
                        n_count      = r_remaining - {5'd0, first_chunk};
                        n_rep_byte   = i_in_byte;
                        n_phase      = PH_HEADER;
                        n_remaining  = 8'd0;
                    end
                    default: begin
                        // Header byte, unused phase code included
                        if (!i_in_byte[7]) begin
                            n_phase     = PH_LITERAL;
                            n_remaining = i_in_byte + 8'd1;
                        end else if (i_in_byte == HDR_SKIP) begin
                            n_phase     = PH_HEADER;
                            n_remaining = 8'd0;
                        end else begin
                            // 1 - h, taken modulo 256, gives 2..128
                            n_phase     = PH_REPEAT;
                            n_remaining = 8'd1 - i_in_byte;
                        end
                    end
                endcase
            end
            if (i_end_of_strip) begin
                n_phase     = PH_HEADER;
                n_remaining = 8'd0;
            end
        end else if (i_cmd.drain_step) begin
            n_out_valid  = 1'b1;
            n_out_byte   = r_rep_byte;
            n_out_copies = next_chunk;
            n_last       = (r_count <= {5'd0, MAX_COPIES});
            n_count      = r_count - {5'd0, next_chunk};
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_remaining <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_count      <= n_count;
        r_rep_byte   <= n_rep_byte;
        r_out_byte   <= n_out_byte;
        r_out_copies <= n_out_copies;
        r_last       <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_out_copies  = r_out_copies;
    assign o_last_of_run = r_last;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the PackBits decoder. Compressed strips go in on
// the input channel; a predictor decodes every accepted byte and queues the
// chunks it expects. Each chunk taken from the output channel is compared
// with the oldest queued one. Directed runs cover the header extremes, the
// skip header and early strip ends. Register tests and pass-through runs
// cover the enable bit. Random strips, mostly well formed, run under varying
// source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb
    import pbd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] copies;
        logic       last;
    } t_run_chunk;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pbd_in_if  in_ch ();
    pbd_out_if out_ch ();

    packbits_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Decoder state as the predictor sees it
    logic       model_enable;
    t_phase     model_phase;
    logic [7:0] model_remaining;

    t_run_chunk pending_chunks[$];

    int error_count   = 0;
    int bytes_sent    = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("packbits_decoder test failed");
            $finish;
        end
    end

    // Decode one accepted byte and queue the chunks it causes
    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        logic [7:0] left;
        logic [7:0] count;
        logic [2:0] take;
        if (!model_enable) begin
            pending_chunks.push_back('{data: b, copies: 3'd1, last: 1'b0});
            model_phase     = PH_HEADER;
            model_remaining = 8'd0;
            return;
        end
        case (model_phase)
            PH_LITERAL: begin
                left = model_remaining - 8'd1;
                pending_chunks.push_back('{data: b, copies: 3'd1,
                                           last: (left == 8'd0) || eos});
                model_remaining = left;
                if (left == 8'd0)
                    model_phase = PH_HEADER;
            end
            PH_REPEAT: begin
                count = model_remaining;
                while (count > 8'd0) begin
                    take  = (count > 8'd4) ? MAX_COPIES : count[2:0];
                    count = count - {5'd0, take};
                    pending_chunks.push_back('{data: b, copies: take,
                                               last: count == 8'd0});
                end
                model_phase     = PH_HEADER;
                model_remaining = 8'd0;
            end
            default: begin
                if (b < HDR_SKIP) begin
                    model_phase     = PH_LITERAL;
                    model_remaining = b + 8'd1;
                end else if (b == HDR_SKIP) begin
                    model_phase     = PH_HEADER;
                    model_remaining = 8'd0;
                end else begin
                    // repeat count 1 - h, h = b - 256
                    model_phase     = PH_REPEAT;
                    model_remaining = 8'(9'd257 - {1'b0, b});
                end
            end
        endcase
        if (eos) begin
            model_phase     = PH_HEADER;
            model_remaining = 8'd0;
        end
    endfunction

    // Check each result taken by the sink, then pick the next ready
    t_run_chunk got_chunk;
    t_run_chunk want_chunk;
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_chunk = '{data: out_ch.out_byte, copies: out_ch.out_copies,
                          last: out_ch.last_of_run};
            if (pending_chunks.size() == 0) begin
                $display("%0t: unexpected result: byte %02h copies %0d last %0b",
                         $time, got_chunk.data, got_chunk.copies, got_chunk.last);
                error_count++;
            end else begin
                want_chunk = pending_chunks.pop_front();
                if (got_chunk !== want_chunk) begin
                    $display({"%0t: mismatch: expected byte %02h copies %0d last %0b,",
                              " actual byte %02h copies %0d last %0b"},
                             $time, want_chunk.data, want_chunk.copies, want_chunk.last,
                             got_chunk.data, got_chunk.copies, got_chunk.last);
                    error_count++;
                end
            end
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Send one request; valid stays high for a following request
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.end_of_strip <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        decode_byte(b, eos);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic settle_outputs();
        in_ch.valid <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup phase, access phase until pready, then idle with psel low
    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (write)
            model_enable = wdata[0];
        @(posedge i_clk);
    endtask

    task automatic set_enable(input logic value);
        logic [PDATA_W-1:0] unused;
        apb_access(1'b1, REG_ENABLE, PDATA_W'(value), unused);
    endtask

    task automatic check_enable_reg(input logic want);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, REG_ENABLE, '0, rd);
        if (rd[0] !== want) begin
            $display("%0t: mismatch: enable register expected %0b, actual %0b",
                     $time, want, rd[0]);
            error_count++;
        end
    endtask

    // Reset value, then write and read back both settings
    task automatic test_register_access();
        check_enable_reg(1'b1);
        set_enable(1'b0);
        check_enable_reg(1'b0);
        set_enable(1'b1);
        check_enable_reg(1'b1);
    endtask

    // Header extremes, skip header, chunk splits and early strip ends
    task automatic test_directed_runs();
        src_idle_pct  = 22;
        sink_idle_pct = 61;
        send_byte(8'h00, 1'b0);   // shortest literal
        send_byte(8'hFF, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFF, 1'b0);   // shortest repeat, two copies
        send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b0);   // longest repeat, 32 chunks
        send_byte(8'hFF, 1'b0);
        send_byte(HDR_SKIP, 1'b0);
        send_byte(8'hFC, 1'b0);   // five copies: full chunk plus one
        send_byte(8'h7E, 1'b0);
        send_byte(8'hFE, 1'b0);   // three copies in one chunk
        send_byte(8'h81, 1'b0);
        send_byte(8'h05, 1'b0);   // literal cut short by strip end
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(8'h03, 1'b1);   // literal header cut off
        send_byte(8'h90, 1'b1);   // repeat header cut off
        send_byte(8'h7F, 1'b0);   // longest literal, cut short
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hF9, 1'b0);   // repeat byte that ends the strip
        send_byte(8'hA5, 1'b1);
        settle_outputs();
    endtask

    // Disabled bytes pass through and clear a pending run
    task automatic test_passthrough();
        src_idle_pct  = 61;
        sink_idle_pct = 22;
        send_byte(8'h02, 1'b0);   // open a literal run, then disable
        settle_outputs();
        set_enable(1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(HDR_SKIP, 1'b0);
        send_byte(8'h7F, 1'b1);
        repeat (8) send_byte(8'($urandom), 1'($urandom));
        settle_outputs();
        set_enable(1'b1);
        send_byte(8'hFE, 1'b0);   // first byte after re-enable is a header
        send_byte(8'h3C, 1'b0);
        settle_outputs();
    endtask

    // One strip: mostly well formed, else noise or cut short
    task automatic send_strip();
        logic [7:0] strip_q[$];
        int         kind;
        int         len;
        int         n_pkts;
        int         n_send;
        logic [7:0] fill;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            // raw noise with random strip ends
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'($urandom));
            return;
        end
        n_pkts = $urandom_range(1, 4);
        repeat (n_pkts) begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128)
                                                       : $urandom_range(1, 6);
                    strip_q.push_back(8'(len - 1));
                    repeat (len) strip_q.push_back(8'($urandom));
                end
                2, 3: begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 128)
                                                      : $urandom_range(2, 12);
                    fill = 8'($urandom);
                    strip_q.push_back(8'(257 - len));
                    strip_q.push_back(fill);
                end
                default: strip_q.push_back(HDR_SKIP);
            endcase
        end
        // cut some strips short at a random byte
        n_send = (kind < 30) ? $urandom_range(1, strip_q.size()) : strip_q.size();
        for (int k = 0; k < n_send; k++)
            send_byte(strip_q[k], k == n_send - 1);
    endtask

    // Random strips under one idling mix, then a disabled burst
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int target);
        int start;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start = bytes_sent;
        while (bytes_sent - start < target) send_strip();
        settle_outputs();
        set_enable(1'b0);
        repeat (10) send_byte(8'($urandom), 1'($urandom));
        settle_outputs();
        set_enable(1'b1);
    endtask

    initial begin
        // Hold every input at a known value
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.in_byte      <= 8'h00;
        in_ch.end_of_strip <= 1'b0;
        model_enable    = 1'b1;
        model_phase     = PH_HEADER;
        model_remaining = 8'd0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_directed_runs();
        test_passthrough();
        test_random_traffic(22, 61, 30);
        test_random_traffic(61, 22, 30);
        test_random_traffic(0, 0, 30);
        settle_outputs();

        if (error_count == 0) begin
            $display("packbits_decoder test passed");
        end else begin
            $display("packbits_decoder test failed");
        end
        $finish;
    end

endmodule
